// ----- hw/rtl/greedy_word_wrap_line_breaker_macros.svh -----
// ---------------------------------------------------------------------------
// Greedy word wrap line breaker: assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef GREEDY_WORD_WRAP_LINE_BREAKER_MACROS_SVH
`define GREEDY_WORD_WRAP_LINE_BREAKER_MACROS_SVH

// Same-cycle implication.
`define GWW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GWW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gww_pkg.sv -----
// ---------------------------------------------------------------------------
// Greedy word wrap line breaker: shared package
// Field widths, register indexes, queue sizing and the row record.
// ---------------------------------------------------------------------------
package gww_pkg;

  // Parameter defaults
  localparam int OFFSET_BITS_DEF = 20;
  localparam int WIDTH_BITS_DEF  = 16;

  // Fixed field widths
  localparam int ROW_BITS       = 20;
  localparam int LEN_BITS       = 3;
  localparam int CFG_INDEX_BITS = 2;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WRAP_ENABLE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ROW_WIDTH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GLYPH_SPACING = 2'd2;

  // Rows per character unit and result queue sizing
  localparam int RES_MAX     = 3;
  localparam int PUSH_BITS   = $clog2(RES_MAX + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // One visual row
  typedef struct packed {
    logic [ROW_BITS-1:0] row_start;
    logic [ROW_BITS-1:0] row_end;
    logic                last_row;
  } gww_row_t;

endpackage

// ----- hw/rtl/gww_row_fifo.sv -----
// ---------------------------------------------------------------------------
// Greedy word wrap line breaker: row queue
// Takes up to RES_MAX rows per cycle, hands them out one transfer at a time.
// ---------------------------------------------------------------------------
module gww_row_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [gww_pkg::PUSH_BITS-1:0]    push_n,
  input  gww_pkg::gww_row_t                push_rows [gww_pkg::RES_MAX],
  output logic                             space_ok,
  output logic                             head_valid,
  input  logic                             head_ready,
  output gww_pkg::gww_row_t                head
);
  import gww_pkg::*;

  gww_row_t              rows [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [CNT_BITS-1:0]   count;
  logic                  pop;
  logic [CNT_BITS-1:0]   count_after_pop;

  assign head_valid      = (count != '0);
  assign head            = rows[rd_ptr];
  assign pop             = head_valid && head_ready;
  assign count_after_pop = count - CNT_BITS'(pop);
  // Room for a full burst of rows once this cycle's transfer leaves
  assign space_ok        = (count_after_pop <= CNT_BITS'(QUEUE_DEPTH - RES_MAX));

  // Write pushed rows
  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (PUSH_BITS'(i) < push_n) begin
        rows[wr_ptr + PTR_BITS'(i)] <= push_rows[i];
      end
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_n);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count  <= count_after_pop + CNT_BITS'(push_n);
    end
  end

endmodule

// ----- hw/rtl/greedy_word_wrap_line_breaker.sv -----
// ---------------------------------------------------------------------------
// Greedy word wrap line breaker: top level
// Cuts a stream of character units into visual rows given as byte ranges.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one character unit per transfer:
//   glyph width (12.4), byte length and the space, newline and end flags.
//   Output channel (out_valid/out_ready) carries one row per transfer:
//   [row_start, row_end) and last_row on the final row of a text.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes
//   wrap_enable, max_row_width or glyph_spacing by cfg_index; write it only
//   while no rows are pending.
// Timing:
//   A unit is processed in the cycle it is accepted; its rows (zero to three)
//   enter the row queue and leave in order, one per cycle while out_ready is
//   high. The input takes one unit per cycle while each unit yields at most
//   one row and out_ready stays high; a unit with k rows takes k transfers.
//   Throughput is set by the four-entry row queue: a unit is accepted whenever
//   three entries will be free after this cycle's output transfer, so input
//   keeps flowing while one row waits on a stalled receiver.
// Reset:
//   rst clears the row state, the queue, and loads wrap_enable = 1,
//   max_row_width = 0 and glyph_spacing = 0. A stalled receiver holds rows
//   in the queue; the input stops once the queue cannot take a full burst.
// ---------------------------------------------------------------------------
module greedy_word_wrap_line_breaker #(
  parameter int OFFSET_BITS = gww_pkg::OFFSET_BITS_DEF,
  parameter int WIDTH_BITS  = gww_pkg::WIDTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gww_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [WIDTH_BITS-1:0]               cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [WIDTH_BITS-1:0]               glyph_width,
  input  logic [gww_pkg::LEN_BITS-1:0]        byte_length,
  input  logic                                is_space,
  input  logic                                is_newline,
  input  logic                                end_of_text,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gww_pkg::ROW_BITS-1:0]        row_start,
  output logic [gww_pkg::ROW_BITS-1:0]        row_end,
  output logic                                last_row
);
  import gww_pkg::*;

  localparam int RW_BITS  = WIDTH_BITS + 4;
  localparam int SUM_BITS = WIDTH_BITS + 6;

  // Configuration registers
  logic                   wrap_enable;
  logic [WIDTH_BITS-1:0]  max_row_width;
  logic [WIDTH_BITS-1:0]  glyph_spacing;

  // Row state
  logic [OFFSET_BITS-1:0] byte_position,      byte_position_next;
  logic [OFFSET_BITS-1:0] current_row_start,  current_row_start_next;
  logic [OFFSET_BITS-1:0] break_position,     break_position_next;
  logic [RW_BITS-1:0]     row_width,          row_width_next;
  logic [RW_BITS-1:0]     width_after_break,  width_after_break_next;
  logic                   row_empty,          row_empty_next;
  logic                   break_valid,        break_valid_next;
  logic                   glyphs_after_break, glyphs_after_break_next;

  // Datapath
  logic                   take;
  logic                   wrapping;
  logic [OFFSET_BITS-1:0] next_pos;
  logic [SUM_BITS-1:0]    sum_row;
  logic [SUM_BITS-1:0]    sum_wab;
  logic                   ovf_row;
  logic                   ovf_wab;
  logic [OFFSET_BITS-1:0] a_start;
  logic                   a_empty;
  logic                   a_bv;
  logic                   a_gab;
  logic [RW_BITS-1:0]     a_wab;
  logic [SUM_BITS-1:0]    acc_sum;
  logic [PUSH_BITS-1:0]   push_n;
  logic [PUSH_BITS-1:0]   push_n_gated;
  gww_row_t               push_rows [RES_MAX];
  logic                   space_ok;
  gww_row_t               head;

  function automatic logic [RW_BITS-1:0] sat_width(input logic [SUM_BITS-1:0] s);
    logic [RW_BITS-1:0] r;
    r = (|s[SUM_BITS-1:RW_BITS]) ? {RW_BITS{1'b1}} : s[RW_BITS-1:0];
    return r;
  endfunction

  function automatic gww_row_t mk_row(input logic [OFFSET_BITS-1:0] s,
                                      input logic [OFFSET_BITS-1:0] e,
                                      input logic last);
    gww_row_t r;
    r.row_start = ROW_BITS'(s);
    r.row_end   = ROW_BITS'(e);
    r.last_row  = last;
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = space_ok;
  assign take      = in_valid && in_ready;

  // Width sums for the current row and for the part after the last break
  assign wrapping = wrap_enable && (max_row_width != '0);
  assign next_pos = byte_position + OFFSET_BITS'(byte_length);
  assign sum_row  = SUM_BITS'(row_width) + SUM_BITS'(glyph_spacing)
                  + SUM_BITS'(glyph_width);
  assign sum_wab  = SUM_BITS'(width_after_break) + SUM_BITS'(glyph_spacing)
                  + SUM_BITS'(glyph_width);
  assign ovf_row  = wrapping && !row_empty && (sum_row > SUM_BITS'(max_row_width));
  assign ovf_wab  = glyphs_after_break && (sum_wab > SUM_BITS'(max_row_width));
  // Accumulate onto the row left after any break
  assign acc_sum  = ovf_row ? sum_wab : sum_row;

  // Process one character unit
  always_comb begin
    byte_position_next      = byte_position;
    current_row_start_next  = current_row_start;
    break_position_next     = break_position;
    row_width_next          = row_width;
    width_after_break_next  = width_after_break;
    row_empty_next          = row_empty;
    break_valid_next        = break_valid;
    glyphs_after_break_next = glyphs_after_break;
    a_start = current_row_start;
    a_empty = row_empty;
    a_bv    = break_valid;
    a_gab   = glyphs_after_break;
    a_wab   = width_after_break;
    push_n  = '0;
    for (int i = 0; i < RES_MAX; i++) begin
      push_rows[i] = '0;
    end

    if (byte_length != '0) begin
      if (is_newline) begin
        // End the logical line and skip the newline bytes
        push_rows[push_n]       = mk_row(current_row_start, byte_position, 1'b0);
        push_n                  = push_n + PUSH_BITS'(1);
        byte_position_next      = next_pos;
        current_row_start_next  = next_pos;
        row_width_next          = '0;
        row_empty_next          = 1'b1;
        break_valid_next        = 1'b0;
        width_after_break_next  = '0;
        glyphs_after_break_next = 1'b0;
      end else begin
        if (ovf_row) begin
          a_bv  = 1'b0;
          a_gab = 1'b0;
          a_wab = '0;
          if (break_valid) begin
            // Break after the last space, carry the trailing word down
            push_rows[push_n] = mk_row(current_row_start, break_position, 1'b0);
            push_n            = push_n + PUSH_BITS'(1);
            if (ovf_wab) begin
              push_rows[push_n] = mk_row(break_position, byte_position, 1'b0);
              push_n            = push_n + PUSH_BITS'(1);
              a_start = byte_position;
              a_empty = 1'b1;
            end else begin
              a_start = break_position;
              a_empty = !glyphs_after_break;
            end
          end else begin
            // No space on the row: break before the glyph
            push_rows[push_n] = mk_row(current_row_start, byte_position, 1'b0);
            push_n            = push_n + PUSH_BITS'(1);
            a_start = byte_position;
            a_empty = 1'b1;
          end
        end
        // Accept the glyph onto the row
        current_row_start_next  = a_start;
        row_width_next          = a_empty ? RW_BITS'(glyph_width) : sat_width(acc_sum);
        break_valid_next        = a_bv;
        width_after_break_next  = a_wab;
        glyphs_after_break_next = a_gab;
        if (a_bv) begin
          width_after_break_next  = a_gab ? sat_width(sum_wab) : RW_BITS'(glyph_width);
          glyphs_after_break_next = 1'b1;
        end
        if (is_space) begin
          break_position_next     = next_pos;
          break_valid_next        = 1'b1;
          width_after_break_next  = '0;
          glyphs_after_break_next = 1'b0;
        end
        row_empty_next     = 1'b0;
        byte_position_next = next_pos;
      end
    end

    if (end_of_text) begin
      // Flush the final row and restart for the next text
      push_rows[push_n]       = mk_row(current_row_start_next, byte_position_next, 1'b1);
      push_n                  = push_n + PUSH_BITS'(1);
      byte_position_next      = '0;
      break_position_next     = '0;
      current_row_start_next  = '0;
      row_width_next          = '0;
      row_empty_next          = 1'b1;
      break_valid_next        = 1'b0;
      width_after_break_next  = '0;
      glyphs_after_break_next = 1'b0;
    end
  end

  assign push_n_gated = take ? push_n : '0;

  // Hold configuration and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_enable        <= 1'b1;
      max_row_width      <= '0;
      glyph_spacing      <= '0;
      byte_position      <= '0;
      current_row_start  <= '0;
      break_position     <= '0;
      row_width          <= '0;
      width_after_break  <= '0;
      row_empty          <= 1'b1;
      break_valid        <= 1'b0;
      glyphs_after_break <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WRAP_ENABLE:   wrap_enable   <= cfg_data[0];
          CFG_MAX_ROW_WIDTH: max_row_width <= cfg_data;
          CFG_GLYPH_SPACING: glyph_spacing <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        byte_position      <= byte_position_next;
        current_row_start  <= current_row_start_next;
        break_position     <= break_position_next;
        row_width          <= row_width_next;
        width_after_break  <= width_after_break_next;
        row_empty          <= row_empty_next;
        break_valid        <= break_valid_next;
        glyphs_after_break <= glyphs_after_break_next;
      end
    end
  end

  // Queue rows toward the output
  gww_row_fifo u_row_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n_gated),
    .push_rows  (push_rows),
    .space_ok   (space_ok),
    .head_valid (out_valid),
    .head_ready (out_ready),
    .head       (head)
  );

  assign row_start = head.row_start;
  assign row_end   = head.row_end;
  assign last_row  = head.last_row;

  `include "greedy_word_wrap_line_breaker_macros.svh"

  `GWW_ASSERT_NEXT(a_eot_row, in_valid && in_ready && end_of_text, out_valid, "end of text gave no row")
  `GWW_ASSERT_NEXT(a_nl_row, in_valid && in_ready && is_newline && (byte_length != '0), out_valid, "newline gave no row")
  `GWW_ASSERT_IMPLY(a_empty_row, row_empty, (row_width == '0) && !break_valid, "empty row carries width or break")
  `GWW_ASSERT_IMPLY(a_break_clear, !break_valid, !glyphs_after_break && (width_after_break == '0), "stale break tracking")

endmodule
